### src/ole_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ole_pkg
// Shared types and constants of the ordered list engine.
// ----------------------------------------------------------------------------
package ole_pkg;

  localparam int OLE_CAPACITY = 64;
  localparam int WORD_W       = 32;
  localparam int POS_W        = 6;
  localparam int OP_W         = 3;
  localparam int LEN_W        = 7;
  localparam int IN_W         = 48;
  localparam int OUT_W        = 40;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND    = 3'd0,
    OP_INSERT_AT = 3'd1,
    OP_DELETE_AT = 3'd2,
    OP_DELETE_VAL= 3'd3,
    OP_REVERSE   = 3'd4,
    OP_READ_AT   = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    CM_HOLD,
    CM_INSERT,
    CM_REMOVE,
    CM_REMOVE_MATCH
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
    logic       capture;
  } cell_ctrl_t;

endpackage

### src/ole_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ole_cell
// One storage slot of the list: holds a word, takes a neighbor's word when
// the row shifts, and registers whether it matches the search key.
// ----------------------------------------------------------------------------
module ole_cell #(
  parameter int IDX = 0,
  parameter int AW  = 6,
  parameter int CW  = 7
) (
  input  logic                       clk,
  input  ole_pkg::cell_ctrl_t        ctrl,
  input  logic [AW-1:0]              pos,
  input  logic [CW-1:0]              count,
  input  logic [ole_pkg::WORD_W-1:0] key,
  input  logic [ole_pkg::WORD_W-1:0] left,
  input  logic [ole_pkg::WORD_W-1:0] right,
  input  logic                       shift_en,
  output logic [ole_pkg::WORD_W-1:0] word_o,
  output logic                       match_o
);

  localparam logic [AW-1:0] KIDX = AW'(IDX);
  localparam logic [CW-1:0] KCNT = CW'(IDX);

  logic [ole_pkg::WORD_W-1:0] word_r;
  logic [ole_pkg::WORD_W-1:0] word_nxt;
  logic                       match_r;

  always_comb begin
    word_nxt = word_r;
    case (ctrl.mode)
      ole_pkg::CM_INSERT: begin
        if (KIDX > pos) begin
          word_nxt = left;
        end else if (KIDX == pos) begin
          word_nxt = key;
        end
      end
      ole_pkg::CM_REMOVE: begin
        if (KIDX >= pos) begin
          word_nxt = right;
        end
      end
      ole_pkg::CM_REMOVE_MATCH: begin
        if (shift_en) begin
          word_nxt = right;
        end
      end
      default: begin
        word_nxt = word_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    if (ctrl.capture) begin
      match_r <= (word_r == key) && (KCNT < count);
    end
  end

  assign word_o  = word_r;
  assign match_o = match_r;

endmodule

### src/ole_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ole_scan
// Finds the first matching slot in list order and marks every slot that
// must shift down to close the gap left by removing it.
// ----------------------------------------------------------------------------
module ole_scan #(
  parameter int N = 64
) (
  input  logic [N-1:0] match,
  input  logic         rev,
  output logic [N-1:0] shift,
  output logic         found
);

  logic [N-1:0] pre;
  logic [N-1:0] suf;

  always_comb begin
    pre = match;
    suf = match;
    for (int s = 1; s < N; s = s * 2) begin
      pre = pre | (pre << s);
      suf = suf | (suf >> s);
    end
  end

  // In reversed order the first match is the highest slot, so every slot
  // with no match above it shifts.
  assign shift = rev ? ~(suf >> 1) : pre;
  assign found = |match;

endmodule

### src/ordered_list_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_engine_top
// Ordered list of signed words kept in a row of cells, one command per word.
// ----------------------------------------------------------------------------
// Each command is accepted in S_IDLE, in which every cell compares itself to
// the key, and is then executed in S_EXEC, in which the cells that must move
// shift together and the result word is registered. No new command is taken
// during S_EXEC or while a result is waiting and out_tready is low.
// Reset clears the count and orientation; the cell contents are not cleared.
// ----------------------------------------------------------------------------
module ordered_list_engine_top #(
  parameter int CAPACITY = ole_pkg::OLE_CAPACITY
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // operation[2:0], position[8:3], word_in[40:9], zero fill above
  input  logic [ole_pkg::IN_W-1:0]  in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // ok[0], length[7:1], word_out[39:8]
  output logic [ole_pkg::OUT_W-1:0] out_tdata
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int PW   = ole_pkg::POS_W;
  localparam int W    = ole_pkg::WORD_W;
  localparam int LW   = ole_pkg::LEN_W;
  localparam int CMPW = (CW > PW) ? CW : PW;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t              state_r;
  logic                out_valid_r;
  logic                out_ok_r;
  logic [LW-1:0]       out_len_r;
  logic [W-1:0]        out_word_r;
  ole_pkg::op_t        cmd_op_r;
  logic [PW-1:0]       cmd_pos_r;
  logic signed [W-1:0] cmd_word_r;
  logic [CW-1:0]       count_r;
  logic                rev_r;

  logic [CW-1:0]       count_nxt;
  logic                rev_nxt;
  logic                ok_nxt;
  logic [W-1:0]        rd_word;
  logic [AW-1:0]       cell_pos;
  logic [AW-1:0]       read_pos;
  ole_pkg::cell_ctrl_t ctrl;
  logic [W-1:0]        key;
  logic                in_acc;

  logic [W-1:0]        word_q [CAPACITY];
  logic [CAPACITY-1:0] match_v;
  logic [CAPACITY-1:0] shift_v;
  logic                found;

  logic [CMPW-1:0]     pos_x;
  logic [CMPW-1:0]     cnt_x;
  logic                in_range;
  logic                not_full;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign key       = (state_r == S_IDLE) ? in_tdata[40:9] : cmd_word_r;

  assign pos_x    = CMPW'(cmd_pos_r);
  assign cnt_x    = CMPW'(count_r);
  assign in_range = pos_x < cnt_x;
  assign not_full = count_r < CW'(CAPACITY);
  assign read_pos = rev_r ? AW'(cnt_x - CMPW'(1) - pos_x) : AW'(pos_x);

  genvar k;
  generate
    for (k = 0; k < CAPACITY; k++) begin : g_cell
      logic [W-1:0] left_w;
      logic [W-1:0] right_w;
      if (k == 0) begin : g_first
        assign left_w = '0;
      end else begin : g_left
        assign left_w = word_q[k-1];
      end
      if (k == CAPACITY - 1) begin : g_last
        assign right_w = word_q[k];
      end else begin : g_right
        assign right_w = word_q[k+1];
      end
      ole_cell #(
        .IDX (k),
        .AW  (AW),
        .CW  (CW)
      ) u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .pos      (cell_pos),
        .count    (count_r),
        .key      (key),
        .left     (left_w),
        .right    (right_w),
        .shift_en (shift_v[k]),
        .word_o   (word_q[k]),
        .match_o  (match_v[k])
      );
    end
  endgenerate

  ole_scan #(
    .N (CAPACITY)
  ) u_scan (
    .match (match_v),
    .rev   (rev_r),
    .shift (shift_v),
    .found (found)
  );

  always_comb begin
    rd_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (AW'(i) == read_pos) begin
        rd_word = rd_word | word_q[i];
      end
    end
  end

  always_comb begin
    ctrl.mode    = ole_pkg::CM_HOLD;
    ctrl.capture = in_acc;
    cell_pos     = read_pos;
    count_nxt    = count_r;
    rev_nxt      = rev_r;
    ok_nxt       = 1'b0;
    if (state_r == S_EXEC) begin
      case (cmd_op_r)
        ole_pkg::OP_APPEND: begin
          if (not_full) begin
            ctrl.mode = ole_pkg::CM_INSERT;
            cell_pos  = rev_r ? '0 : AW'(count_r);
            count_nxt = count_r + CW'(1);
            ok_nxt    = 1'b1;
          end
        end
        ole_pkg::OP_INSERT_AT: begin
          if (in_range && not_full) begin
            ctrl.mode = ole_pkg::CM_INSERT;
            cell_pos  = rev_r ? AW'(cnt_x - pos_x) : AW'(pos_x);
            count_nxt = count_r + CW'(1);
            ok_nxt    = 1'b1;
          end
        end
        ole_pkg::OP_DELETE_AT: begin
          if (in_range) begin
            ctrl.mode = ole_pkg::CM_REMOVE;
            count_nxt = count_r - CW'(1);
            rev_nxt   = rev_r && (count_r != CW'(1));
            ok_nxt    = 1'b1;
          end
        end
        ole_pkg::OP_DELETE_VAL: begin
          if (found) begin
            ctrl.mode = ole_pkg::CM_REMOVE_MATCH;
            count_nxt = count_r - CW'(1);
            rev_nxt   = rev_r && (count_r != CW'(1));
            ok_nxt    = 1'b1;
          end
        end
        ole_pkg::OP_REVERSE: begin
          if (count_r > CW'(1)) begin
            rev_nxt = ~rev_r;
          end
          ok_nxt = 1'b1;
        end
        ole_pkg::OP_READ_AT: begin
          ok_nxt = in_range;
        end
        default: begin
          ok_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      rev_r       <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (out_valid_r && out_tready) begin
            out_valid_r <= 1'b0;
          end
          if (in_acc) begin
            state_r    <= S_EXEC;
            cmd_op_r   <= ole_pkg::op_t'(in_tdata[2:0]);
            cmd_pos_r  <= in_tdata[8:3];
            cmd_word_r <= in_tdata[40:9];
          end
        end
        S_EXEC: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b1;
          out_ok_r    <= ok_nxt;
          out_len_r   <= LW'(count_nxt);
          out_word_r  <= (cmd_op_r == ole_pkg::OP_READ_AT && ok_nxt) ? rd_word : '0;
          count_r     <= count_nxt;
          rev_r       <= rev_nxt;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_word_r, out_len_r, out_ok_r};

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("element count exceeds capacity");

  a_rev_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    rev_r |-> (count_r != '0))
    else $error("reversed orientation set on an empty list");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> ##1 out_valid_r)
    else $error("result word missing two cycles after accept");

endmodule
